// File: hdl/mecanum_wheel_mixer_defines.svh
// Assertion macros shared by the mixer RTL.
// They expand to concurrent assertions in simulation and to nothing in synthesis.
`ifndef MECANUM_WHEEL_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_MIXER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define MWM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mixer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mixer assertion failed");

`else

`define MWM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MWM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/mwm_pkg.sv
package mwm_pkg;

    localparam int NUM_WHEELS = 4;
    localparam int VEL_W      = 16;
    localparam int WHEEL_W    = 16;
    localparam int LIMIT_W    = 15;
    // Sum of three 16-bit signed values needs two extra bits.
    localparam int MIX_W      = VEL_W + 2;
    localparam int MAG_W      = MIX_W - 1;
    localparam int PROD_W     = MAG_W + LIMIT_W;
    // The scaled quotient never exceeds the limit, so it has LIMIT_W bits.
    localparam int DIV_STEPS  = LIMIT_W;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [PROD_W-1:0] work_t;

    // Payload of the product stage and of every divider stage.
    typedef struct packed {
        logic                                    scale;
        logic [NUM_WHEELS-1:0]                   neg;
        mag_t                                    peak;
        logic [NUM_WHEELS-1:0][WHEEL_W-1:0]      raw;
        logic [NUM_WHEELS-1:0][PROD_W-1:0]       work;
    } div_stage_t;

    // One restoring division step. The working word holds the partial
    // remainder in its upper MAG_W bits and the remaining dividend bits,
    // replaced one by one with quotient bits, in its lower DIV_STEPS bits.
    function automatic work_t div_step(input work_t work, input mag_t divisor);
        logic [MAG_W:0] trial;
        logic [MAG_W:0] diff;
        work_t          res;
        trial = work[PROD_W-1 -: MAG_W+1];
        diff  = trial - {1'b0, divisor};
        if (trial >= {1'b0, divisor})
        begin
            res = {diff[MAG_W-1:0], work[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            res = {trial[MAG_W-1:0], work[DIV_STEPS-2:0], 1'b0};
        end
        return res;
    endfunction

    function automatic logic [WHEEL_W-1:0] wheel_abs(input logic signed [WHEEL_W-1:0] v);
        logic [WHEEL_W-1:0] res;
        res = v[WHEEL_W-1] ? WHEEL_W'(-v) : WHEEL_W'(v);
        return res;
    endfunction

endpackage

// File: hdl/mwm_cmd_if.sv
interface mwm_cmd_if;
    import mwm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VEL_W-1:0] vel_forward;
    logic signed [VEL_W-1:0] vel_sideways;
    logic signed [VEL_W-1:0] vel_rotate;

    modport source (output valid, output vel_forward, output vel_sideways,
                    output vel_rotate, input ready);
    modport sink   (input valid, input vel_forward, input vel_sideways,
                    input vel_rotate, output ready);
endinterface

// File: hdl/mwm_spd_if.sv
interface mwm_spd_if;
    import mwm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WHEEL_W-1:0] wheel_front_left;
    logic signed [WHEEL_W-1:0] wheel_front_right;
    logic signed [WHEEL_W-1:0] wheel_rear_left;
    logic signed [WHEEL_W-1:0] wheel_rear_right;
    logic                      was_scaled;

    modport source (output valid, output wheel_front_left, output wheel_front_right,
                    output wheel_rear_left, output wheel_rear_right,
                    output was_scaled, input ready);
    modport sink   (input valid, input wheel_front_left, input wheel_front_right,
                    input wheel_rear_left, input wheel_rear_right,
                    input was_scaled, output ready);
endinterface

// File: hdl/mecanum_wheel_mixer.sv
// A command passes through 20 register stages before its speed result is presented.
// Throughput: one command per cycle unless the output stalls; the 15 one-bit restoring
// division stages are pipelined. Each stage holds its item during an output stall and
// takes a new one into any bubble.
// Reset (rst_n, asynchronous, active low) empties the pipeline and sets speed_limit to 100.
// Datapath registers carry no reset; only the valid bits and the limit register do.
`include "mecanum_wheel_mixer_defines.svh"

module mecanum_wheel_mixer (
    input  logic                          clk,
    input  logic                          rst_n,
    mwm_cmd_if.sink                       cmd,
    mwm_spd_if.source                     spd,
    input  logic                          cfg_wr_en,
    input  logic [mwm_pkg::LIMIT_W-1:0]   cfg_wr_data
);
    import mwm_pkg::*;

    // Speed limit register. The user must rewrite it only while the pipeline is empty, so that
    // every stage may read it directly; the block itself does not enforce this.
    logic [LIMIT_W-1:0] speed_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            speed_limit_reg <= cfg_wr_data;
        end
    end

    // Stage enables. A stage loads whenever it is empty or the stage after it
    // loads in the same cycle, so bubbles are squeezed out and nothing is lost
    // or repeated during a stall.
    logic                 s1_v_reg;
    logic                 s2_v_reg;
    logic                 s3_v_reg;
    logic [DIV_STEPS:0]   dp_v_reg;
    logic                 out_v_reg;

    logic                 s1_en;
    logic                 s2_en;
    logic                 s3_en;
    logic [DIV_STEPS:0]   dp_en;
    logic                 out_en;

    assign out_en = !out_v_reg || spd.ready;
    assign dp_en[DIV_STEPS] = !dp_v_reg[DIV_STEPS] || out_en;

    for (genvar gk = 0; gk < DIV_STEPS; gk++)
    begin : g_div_en
        assign dp_en[gk] = !dp_v_reg[gk] || dp_en[gk+1];
    end

    assign s3_en     = !s3_v_reg || dp_en[0];
    assign s2_en     = !s2_v_reg || s3_en;
    assign s1_en     = !s1_v_reg || s2_en;
    assign cmd.ready = s1_en;

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            dp_v_reg  <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_v_reg <= cmd.valid;
            end
            if (s2_en)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_en)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (dp_en[0])
            begin
                dp_v_reg[0] <= s3_v_reg;
            end
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                if (dp_en[k])
                begin
                    dp_v_reg[k] <= dp_v_reg[k-1];
                end
            end
            if (out_en)
            begin
                out_v_reg <= dp_v_reg[DIV_STEPS];
            end
        end
    end

    // Stage 1: the four wheel mixes. Wheels 1 and 3 are mounted mirrored, so
    // their mixes are negated here: -(f - s - r) and -(f + s - r).
    logic signed [MIX_W-1:0] fwd_ext;
    logic signed [MIX_W-1:0] side_ext;
    logic signed [MIX_W-1:0] rot_ext;
    logic signed [MIX_W-1:0] mix_next [NUM_WHEELS];
    logic signed [MIX_W-1:0] mix_reg  [NUM_WHEELS];

    assign fwd_ext  = MIX_W'(cmd.vel_forward);
    assign side_ext = MIX_W'(cmd.vel_sideways);
    assign rot_ext  = MIX_W'(cmd.vel_rotate);

    always_comb
    begin
        mix_next[0] =  fwd_ext + side_ext + rot_ext;
        mix_next[1] = -fwd_ext + side_ext + rot_ext;
        mix_next[2] =  fwd_ext - side_ext + rot_ext;
        mix_next[3] = -fwd_ext - side_ext + rot_ext;
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                mix_reg[k] <= mix_next[k];
            end
        end
    end

    // Stage 2: sign and magnitude of each mix. The low 16 bits of the mix are
    // kept as the unscaled speed; when no scaling happens it already fits.
    logic [NUM_WHEELS-1:0]              s2_neg_reg;
    mag_t                               s2_mag_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0][WHEEL_W-1:0] s2_raw_reg;

    always_ff @(posedge clk)
    begin
        if (s2_en)
        begin
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                s2_neg_reg[k] <= mix_reg[k][MIX_W-1];
                s2_mag_reg[k] <= mix_reg[k][MIX_W-1] ? MAG_W'(-mix_reg[k])
                                                     : MAG_W'(mix_reg[k]);
                s2_raw_reg[k] <= mix_reg[k][WHEEL_W-1:0];
            end
        end
    end

    // Stage 3: the peak magnitude over a two-level compare tree, and the
    // decision to scale. A peak exactly at the limit is not scaled.
    mag_t peak_a;
    mag_t peak_b;
    mag_t peak_next;

    assign peak_a    = (s2_mag_reg[0] > s2_mag_reg[1]) ? s2_mag_reg[0] : s2_mag_reg[1];
    assign peak_b    = (s2_mag_reg[2] > s2_mag_reg[3]) ? s2_mag_reg[2] : s2_mag_reg[3];
    assign peak_next = (peak_a > peak_b) ? peak_a : peak_b;

    logic [NUM_WHEELS-1:0]              s3_neg_reg;
    mag_t                               s3_mag_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0][WHEEL_W-1:0] s3_raw_reg;
    mag_t                               s3_peak_reg;
    logic                               s3_scale_reg;

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            s3_neg_reg   <= s2_neg_reg;
            s3_raw_reg   <= s2_raw_reg;
            s3_peak_reg  <= peak_next;
            s3_scale_reg <= peak_next > MAG_W'(speed_limit_reg);
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                s3_mag_reg[k] <= s2_mag_reg[k];
            end
        end
    end

    // Stage 4 (divider entry): product of each magnitude with the limit. The
    // quotient product / peak is below 2^LIMIT_W whenever scaling applies, so
    // the upper MAG_W bits of the product already form the starting remainder.
    div_stage_t dp_next;
    div_stage_t dp_reg [DIV_STEPS+1];

    always_comb
    begin
        dp_next.scale = s3_scale_reg;
        dp_next.neg   = s3_neg_reg;
        dp_next.peak  = s3_peak_reg;
        dp_next.raw   = s3_raw_reg;
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            dp_next.work[k] = s3_mag_reg[k] * speed_limit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_en[0])
        begin
            dp_reg[0] <= dp_next;
        end
    end

    // Divider stages: one restoring step per stage for all four wheels, each
    // dividing by the shared peak. The result is truncated toward zero once
    // the sign is put back at the output.
    for (genvar gs = 1; gs <= DIV_STEPS; gs++)
    begin : g_div
        div_stage_t step_next;

        always_comb
        begin
            step_next = dp_reg[gs-1];
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                step_next.work[k] = div_step(dp_reg[gs-1].work[k], dp_reg[gs-1].peak);
            end
        end

        always_ff @(posedge clk)
        begin
            if (dp_en[gs])
            begin
                dp_reg[gs] <= step_next;
            end
        end
    end

    // Output register: pick the scaled quotient or the unscaled mix, and
    // restore the sign of scaled speeds.
    div_stage_t                         dp_last;
    logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel_next;
    logic [NUM_WHEELS-1:0][WHEEL_W-1:0] wheel_reg;
    logic                               scaled_reg;
    logic [WHEEL_W-1:0]                 quot;

    assign dp_last = dp_reg[DIV_STEPS];

    always_comb
    begin
        for (int k = 0; k < NUM_WHEELS; k++)
        begin
            quot = WHEEL_W'(dp_last.work[k][DIV_STEPS-1:0]);
            if (dp_last.scale)
            begin
                wheel_next[k] = dp_last.neg[k] ? WHEEL_W'(-quot) : quot;
            end
            else
            begin
                wheel_next[k] = dp_last.raw[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            wheel_reg  <= wheel_next;
            scaled_reg <= dp_last.scale;
        end
    end

    assign spd.valid             = out_v_reg;
    assign spd.wheel_front_left  = wheel_reg[0];
    assign spd.wheel_front_right = wheel_reg[1];
    assign spd.wheel_rear_left   = wheel_reg[2];
    assign spd.wheel_rear_right  = wheel_reg[3];
    assign spd.was_scaled        = scaled_reg;

    // A command transfer always lands in the first stage.
    `MWM_ASSERT_NEXT(a_cmd_enters, clk, rst_n, cmd.valid && cmd.ready, s1_v_reg)

    // Whether scaled or not, no wheel speed may exceed the limit.
    `MWM_ASSERT_SAME(a_within_limit, clk, rst_n, spd.valid,
        wheel_abs(spd.wheel_front_left) <= WHEEL_W'(speed_limit_reg) &&
        wheel_abs(spd.wheel_front_right) <= WHEEL_W'(speed_limit_reg) &&
        wheel_abs(spd.wheel_rear_left) <= WHEEL_W'(speed_limit_reg) &&
        wheel_abs(spd.wheel_rear_right) <= WHEEL_W'(speed_limit_reg))

    // When scaling happened, the wheel that set the peak lands exactly on the limit.
    `MWM_ASSERT_SAME(a_peak_on_limit, clk, rst_n, spd.valid && spd.was_scaled,
        wheel_abs(spd.wheel_front_left) == WHEEL_W'(speed_limit_reg) ||
        wheel_abs(spd.wheel_front_right) == WHEEL_W'(speed_limit_reg) ||
        wheel_abs(spd.wheel_rear_left) == WHEEL_W'(speed_limit_reg) ||
        wheel_abs(spd.wheel_rear_right) == WHEEL_W'(speed_limit_reg))

endmodule
